// ===== hw/rtl/rpcd_pkg.sv =====
package rpcd_pkg;

    localparam int CFG_WIDTH          = 15;
    localparam int LEN_WIDTH          = 6;
    localparam int CODE_WIDTH         = 32;
    localparam int CFG_IDX_WIDTH      = 3;
    localparam int DURATION_WIDTH_DEF = 15;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TOLERANCE   = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SYNC_HIGH   = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SYNC_LOW    = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SHORT_TIME  = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_LONG_TIME   = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CODE_LENGTH = 3'd5;

    // Reset values
    localparam logic [CFG_WIDTH-1:0] TOLERANCE_RST   = 15'd200;
    localparam logic [CFG_WIDTH-1:0] SYNC_HIGH_RST   = 15'd300;
    localparam logic [CFG_WIDTH-1:0] SYNC_LOW_RST    = 15'd9300;
    localparam logic [CFG_WIDTH-1:0] SHORT_TIME_RST  = 15'd300;
    localparam logic [CFG_WIDTH-1:0] LONG_TIME_RST   = 15'd900;
    localparam logic [LEN_WIDTH-1:0] CODE_LENGTH_RST = 6'd24;
    localparam logic [LEN_WIDTH-1:0] CODE_LENGTH_MAX = 6'd32;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] tolerance;
        logic [CFG_WIDTH-1:0] sync_high_time;
        logic [CFG_WIDTH-1:0] sync_low_time;
        logic [CFG_WIDTH-1:0] short_time;
        logic [CFG_WIDTH-1:0] long_time;
    } timing_cfg_t;

    typedef struct packed {
        logic sync_pair;
        logic zero_pair;
        logic one_pair;
    } pair_match_t;

endpackage

// ===== hw/rtl/rpcd_pair_judge.sv =====
module rpcd_pair_judge #(
    parameter int DURATION_WIDTH = rpcd_pkg::DURATION_WIDTH_DEF
) (
    input  logic                      held_level,
    input  logic [DURATION_WIDTH-1:0] held_duration,
    input  logic                      pulse_level,
    input  logic [DURATION_WIDTH-1:0] pulse_duration,
    input  rpcd_pkg::timing_cfg_t     timing,
    output rpcd_pkg::pair_match_t     match
);
    import rpcd_pkg::*;

    // Wide enough for duration + tolerance and target + tolerance without overflow
    localparam int CW = ((DURATION_WIDTH > CFG_WIDTH + 1) ? DURATION_WIDTH : CFG_WIDTH + 1) + 1;

    // Strictly inside (t - tol, t + tol); lower bound rearranged to v + tol > t
    function automatic logic near(input logic [DURATION_WIDTH-1:0] v,
                                  input logic [CFG_WIDTH-1:0]      t,
                                  input logic [CFG_WIDTH-1:0]      tol);
        logic [CW-1:0] ve;
        logic [CW-1:0] te;
        logic [CW-1:0] tole;
        ve   = CW'(v);
        te   = CW'(t);
        tole = CW'(tol);
        return ((ve + tole) > te) && (ve < (te + tole));
    endfunction

    logic high_low;

    assign high_low = held_level && !pulse_level;

    assign match.sync_pair = high_low
        && near(held_duration, timing.sync_high_time, timing.tolerance)
        && near(pulse_duration, timing.sync_low_time, timing.tolerance);

    assign match.zero_pair = high_low
        && near(held_duration, timing.short_time, timing.tolerance)
        && near(pulse_duration, timing.long_time, timing.tolerance);

    assign match.one_pair = high_low
        && near(held_duration, timing.long_time, timing.tolerance)
        && near(pulse_duration, timing.short_time, timing.tolerance);

endmodule

// ===== hw/rtl/rf_pulse_code_decoder_core.sv =====
// Channel  | Handshake          | Payload
// ---------+--------------------+-------------------------------------------------
// input    | s_valid / s_ready  | s_pulse_level, s_pulse_duration, s_frame_start
// result   | m_valid / m_ready  | m_code
// config   | cfg_wr_en          | cfg_addr, cfg_wr_data (write only, no wait)
//
// One pulse item per cycle sustained while s_ready is high. An item is registered at
// acceptance and judged in the next cycle; a finished code raises m_valid when its
// last pulse leaves the input register, which a code still waiting at the output can delay.
// Reset (aresetn low at a clock edge) clears decoder state, empties both
// registers and loads the default timing.
// s_ready drops only while a code-bearing item waits behind an untaken code in
// the output register; items that carry no code always pass.
module rf_pulse_code_decoder_core #(
    parameter int DURATION_WIDTH = rpcd_pkg::DURATION_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_pulse_level,
    input  logic [DURATION_WIDTH-1:0]            s_pulse_duration,
    input  logic                                 s_frame_start,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rpcd_pkg::CODE_WIDTH-1:0]      m_code,

    input  logic                                 cfg_wr_en,
    input  logic [rpcd_pkg::CFG_IDX_WIDTH-1:0]   cfg_addr,
    input  logic [rpcd_pkg::CFG_WIDTH-1:0]       cfg_wr_data
);
    import rpcd_pkg::*;

    // Configuration registers
    timing_cfg_t           timing_reg;
    logic [LEN_WIDTH-1:0]  code_length_reg;

    // Input register
    logic                      in_valid_reg;
    logic                      in_level_reg;
    logic [DURATION_WIDTH-1:0] in_duration_reg;
    logic                      in_frame_start_reg;

    // Decoder state
    logic                      held_valid_reg,    held_valid_next;
    logic                      held_level_reg,    held_level_next;
    logic [DURATION_WIDTH-1:0] held_duration_reg, held_duration_next;
    logic                      synced_reg,        synced_next;
    logic [LEN_WIDTH-1:0]      bits_received_reg, bits_received_next;
    logic [CODE_WIDTH-1:0]     shift_code_reg,    shift_code_next;

    // Output register
    logic                  out_valid_reg;
    logic [CODE_WIDTH-1:0] out_code_reg;

    // State after an optional frame-start clear
    logic                      cur_held_valid;
    logic                      cur_held_level;
    logic [DURATION_WIDTH-1:0] cur_held_duration;
    logic                      cur_synced;
    logic [LEN_WIDTH-1:0]      cur_bits_received;
    logic [CODE_WIDTH-1:0]     cur_shift_code;

    logic [LEN_WIDTH-1:0] eff_length;
    pair_match_t          match;
    logic                 emit;
    logic                 fire;
    logic                 s_accept;

    // ------------------------------------------------------------------
    // Configuration writes; out-of-list indexes are ignored
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.tolerance      <= TOLERANCE_RST;
            timing_reg.sync_high_time <= SYNC_HIGH_RST;
            timing_reg.sync_low_time  <= SYNC_LOW_RST;
            timing_reg.short_time     <= SHORT_TIME_RST;
            timing_reg.long_time      <= LONG_TIME_RST;
            code_length_reg           <= CODE_LENGTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_TOLERANCE:   timing_reg.tolerance      <= cfg_wr_data;
                REG_SYNC_HIGH:   timing_reg.sync_high_time <= cfg_wr_data;
                REG_SYNC_LOW:    timing_reg.sync_low_time  <= cfg_wr_data;
                REG_SHORT_TIME:  timing_reg.short_time     <= cfg_wr_data;
                REG_LONG_TIME:   timing_reg.long_time      <= cfg_wr_data;
                REG_CODE_LENGTH: code_length_reg           <= cfg_wr_data[LEN_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // A length of zero or above the code width means a full-width code
    assign eff_length = (code_length_reg == '0 || code_length_reg > CODE_LENGTH_MAX)
                        ? CODE_LENGTH_MAX : code_length_reg;

    // ------------------------------------------------------------------
    // Handshakes: the held item advances unless it carries a code that
    // would overwrite one still waiting in the output register
    // ------------------------------------------------------------------
    assign fire     = in_valid_reg && (!emit || !out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || fire;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_level_reg       <= s_pulse_level;
            in_duration_reg    <= s_pulse_duration;
            in_frame_start_reg <= s_frame_start;
        end
    end

    // ------------------------------------------------------------------
    // Pair decision
    // ------------------------------------------------------------------
    // Frame start wipes all decoder state before the pulse is looked at
    always_comb begin
        if (in_frame_start_reg) begin
            cur_held_valid    = 1'b0;
            cur_held_level    = 1'b0;
            cur_held_duration = '0;
            cur_synced        = 1'b0;
            cur_bits_received = '0;
            cur_shift_code    = '0;
        end else begin
            cur_held_valid    = held_valid_reg;
            cur_held_level    = held_level_reg;
            cur_held_duration = held_duration_reg;
            cur_synced        = synced_reg;
            cur_bits_received = bits_received_reg;
            cur_shift_code    = shift_code_reg;
        end
    end

    rpcd_pair_judge #(
        .DURATION_WIDTH (DURATION_WIDTH)
    ) u_judge (
        .held_level     (cur_held_level),
        .held_duration  (cur_held_duration),
        .pulse_level    (in_level_reg),
        .pulse_duration (in_duration_reg),
        .timing         (timing_reg),
        .match          (match)
    );

    always_comb begin
        held_valid_next    = cur_held_valid;
        held_level_next    = cur_held_level;
        held_duration_next = cur_held_duration;
        synced_next        = cur_synced;
        bits_received_next = cur_bits_received;
        shift_code_next    = cur_shift_code;
        emit               = 1'b0;

        if (!cur_held_valid) begin
            // First pulse of a pair: hold it
            held_valid_next    = 1'b1;
            held_level_next    = in_level_reg;
            held_duration_next = in_duration_reg;
        end else if (!cur_synced) begin
            if (match.sync_pair) begin
                synced_next        = 1'b1;
                bits_received_next = '0;
                shift_code_next    = '0;
                held_valid_next    = 1'b0;
            end else begin
                // Drop the older pulse, keep the new one as a sync candidate
                held_level_next    = in_level_reg;
                held_duration_next = in_duration_reg;
            end
        end else begin
            if (match.zero_pair || match.one_pair) begin
                shift_code_next = {cur_shift_code[CODE_WIDTH-2:0],
                                   match.one_pair && !match.zero_pair};
                // Saturate so a count past any legal length never wraps back
                if (cur_bits_received != '1) begin
                    bits_received_next = cur_bits_received + 1'b1;
                end
                held_valid_next = 1'b0;
            end else begin
                // Not a data bit: lose sync, re-examine this pulse as a sync start
                synced_next        = 1'b0;
                held_level_next    = in_level_reg;
                held_duration_next = in_duration_reg;
            end

            if (synced_next && bits_received_next == eff_length) begin
                synced_next = 1'b0;
                emit        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg    <= 1'b0;
            held_level_reg    <= 1'b0;
            held_duration_reg <= '0;
            synced_reg        <= 1'b0;
            bits_received_reg <= '0;
            shift_code_reg    <= '0;
        end else if (fire) begin
            held_valid_reg    <= held_valid_next;
            held_level_reg    <= held_level_next;
            held_duration_reg <= held_duration_next;
            synced_reg        <= synced_next;
            bits_received_reg <= bits_received_next;
            shift_code_reg    <= shift_code_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: load a finished code, clear when taken
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            out_code_reg <= shift_code_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_code  = out_code_reg;

endmodule

// ===== hw/rtl/rpcd_checker.sv =====
module rpcd_checker #(
    parameter int DURATION_WIDTH = rpcd_pkg::DURATION_WIDTH_DEF
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 s_pulse_level,
    input logic [DURATION_WIDTH-1:0]            s_pulse_duration,
    input logic                                 s_frame_start,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [rpcd_pkg::CODE_WIDTH-1:0]      m_code
);
    import rpcd_pkg::*;

    // An untaken code holds its value
    a_code_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code))
        else $error("result item changed while stalled");

    // A stalled pulse item stays offered with the same payload
    a_item_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_pulse_level)
            && $stable(s_pulse_duration) && $stable(s_frame_start))
        else $error("input item changed while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Input backpressure only while a code is stuck at the output
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a blocked result");

    // A fresh code follows an accepted input item
    a_code_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result item without a matching input item");

endmodule

bind rf_pulse_code_decoder_core rpcd_checker #(
    .DURATION_WIDTH (DURATION_WIDTH)
) u_rpcd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_pulse_level    (s_pulse_level),
    .s_pulse_duration (s_pulse_duration),
    .s_frame_start    (s_frame_start),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_code           (m_code)
);
